// ----- rtl/vsg_pkg.sv -----
// Package for the velocity shaper: widths, fixed-point format, register map,
// run phase codes and the word types of both channels.
// No dependencies.
package vsg_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int FX_W       = FRAC_BITS + 16;
	localparam int ALPHA_BITS = 16;
	localparam int VEL_W      = 12;
	localparam int POS_W      = 24;
	localparam int RANGE_W    = 16;
	localparam int TIME_W     = 32;
	localparam int ADDR_W     = 5;
	localparam int DATA_W     = 32;

	localparam logic [RANGE_W-1:0] NEAR_WINDOW_MM = 16'd250;
	localparam logic [VEL_W-1:0]   VEL_LIMIT      = 12'd2000;
	localparam logic [9:0]         MS_PER_S       = 10'd1000;

	localparam logic signed [VEL_W-1:0] BASE_VELOCITY_RST   = 12'sd500;
	localparam logic [15:0]             TARGET_DISTANCE_RST = 16'd3500;
	localparam logic [ALPHA_BITS-1:0]   SMOOTHING_ALPHA_RST = 16'd9362;
	localparam logic [11:0]             MAX_STEP_CHANGE_RST = 12'd40;
	localparam logic [15:0]             AVOID_DISTANCE_RST  = 16'd200;
	localparam logic [10:0]             PUSH_VELOCITY_RST   = 11'd500;
	localparam logic [15:0]             STEP_THRESHOLD_RST  = 16'd20;
	localparam logic [15:0]             RATE_THRESHOLD_RST  = 16'd300;

	typedef enum logic [1:0] {
		PH_MOVING  = 2'd0,
		PH_WAITING = 2'd1,
		PH_REACHED = 2'd2,
		PH_SPIKE   = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		REG_BASE_VELOCITY   = 3'd0,
		REG_TARGET_DISTANCE = 3'd1,
		REG_SMOOTHING_ALPHA = 3'd2,
		REG_MAX_STEP_CHANGE = 3'd3,
		REG_AVOID_DISTANCE  = 3'd4,
		REG_PUSH_VELOCITY   = 3'd5,
		REG_STEP_THRESHOLD  = 3'd6,
		REG_RATE_THRESHOLD  = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		logic signed [VEL_W-1:0]   base_velocity;
		logic [15:0]               target_distance;
		logic [ALPHA_BITS-1:0]     smoothing_alpha;
		logic [11:0]               max_step_change;
		logic [15:0]               avoid_distance;
		logic [10:0]               push_velocity;
		logic [15:0]               step_threshold;
		logic [15:0]               rate_threshold;
	} cfg_t;

	typedef struct packed {
		logic                      restart;
		logic                      position_valid;
		logic signed [POS_W-1:0]   position_x;
		logic signed [POS_W-1:0]   position_y;
		logic                      down_valid;
		logic [RANGE_W-1:0]        down_range;
		logic [TIME_W-1:0]         time_ms;
		logic [RANGE_W-1:0]        front_range;
		logic [RANGE_W-1:0]        back_range;
		logic [RANGE_W-1:0]        left_range;
		logic [RANGE_W-1:0]        right_range;
	} in_word_t;

	typedef struct packed {
		logic signed [VEL_W-1:0]   command_vx;
		logic signed [VEL_W-1:0]   command_vy;
		logic [1:0]                run_status;
	} out_word_t;

	typedef struct packed {
		logic reached;
		logic spike;
	} guard_t;

endpackage

// ----- rtl/vsg_cfg.sv -----
// Configuration register file behind an APB-style port.
// Depends on vsg_pkg (register map, reset values, cfg_t).
module vsg_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [vsg_pkg::ADDR_W-1:0]   paddr,
	input  logic [vsg_pkg::DATA_W-1:0]   pwdata,
	output logic [vsg_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output vsg_pkg::cfg_t                cfg
);
	import vsg_pkg::*;

	cfg_t     cfg_q;
	cfg_reg_t idx;
	logic     wr_en;

	assign idx    = cfg_reg_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_velocity   <= BASE_VELOCITY_RST;
			cfg_q.target_distance <= TARGET_DISTANCE_RST;
			cfg_q.smoothing_alpha <= SMOOTHING_ALPHA_RST;
			cfg_q.max_step_change <= MAX_STEP_CHANGE_RST;
			cfg_q.avoid_distance  <= AVOID_DISTANCE_RST;
			cfg_q.push_velocity   <= PUSH_VELOCITY_RST;
			cfg_q.step_threshold  <= STEP_THRESHOLD_RST;
			cfg_q.rate_threshold  <= RATE_THRESHOLD_RST;
		end else if (wr_en) begin
			case (idx)
				REG_BASE_VELOCITY:   cfg_q.base_velocity   <= pwdata[VEL_W-1:0];
				REG_TARGET_DISTANCE: cfg_q.target_distance <= pwdata[15:0];
				REG_SMOOTHING_ALPHA: cfg_q.smoothing_alpha <= pwdata[ALPHA_BITS-1:0];
				REG_MAX_STEP_CHANGE: cfg_q.max_step_change <= pwdata[11:0];
				REG_AVOID_DISTANCE:  cfg_q.avoid_distance  <= pwdata[15:0];
				REG_PUSH_VELOCITY:   cfg_q.push_velocity   <= pwdata[10:0];
				REG_STEP_THRESHOLD:  cfg_q.step_threshold  <= pwdata[15:0];
				REG_RATE_THRESHOLD:  cfg_q.rate_threshold  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_BASE_VELOCITY:   prdata = DATA_W'($unsigned(cfg_q.base_velocity));
			REG_TARGET_DISTANCE: prdata = DATA_W'(cfg_q.target_distance);
			REG_SMOOTHING_ALPHA: prdata = DATA_W'(cfg_q.smoothing_alpha);
			REG_MAX_STEP_CHANGE: prdata = DATA_W'(cfg_q.max_step_change);
			REG_AVOID_DISTANCE:  prdata = DATA_W'(cfg_q.avoid_distance);
			REG_PUSH_VELOCITY:   prdata = DATA_W'(cfg_q.push_velocity);
			REG_STEP_THRESHOLD:  prdata = DATA_W'(cfg_q.step_threshold);
			REG_RATE_THRESHOLD:  prdata = DATA_W'(cfg_q.rate_threshold);
			default:             prdata = '0;
		endcase
	end

endmodule

// ----- rtl/vsg_guard.sv -----
// Stop checks for one word: travel distance against the target and the
// down-range spike test. Pure combinational. Depends on vsg_pkg.
module vsg_guard (
	input  vsg_pkg::in_word_t                 word,
	input  logic signed [vsg_pkg::POS_W-1:0]  origin_x,
	input  logic signed [vsg_pkg::POS_W-1:0]  origin_y,
	input  vsg_pkg::cfg_t                     cfg,
	input  logic [vsg_pkg::RANGE_W-1:0]       last_down,
	input  logic [vsg_pkg::TIME_W-1:0]        last_time,
	input  logic                              last_seen,
	output vsg_pkg::guard_t                   flags
);
	import vsg_pkg::*;

	localparam int DW = POS_W + 1;
	localparam int SW = 2 * DW;
	localparam int DIST_W = SW + 1;

	logic signed [DW-1:0]      dx, dy;
	logic signed [SW-1:0]      sqx, sqy;
	logic [DIST_W-1:0]         dist2;
	logic [31:0]               tgt_sq, near_sq;
	logic [15:0]               tgt_near;
	logic                      near;
	logic signed [RANGE_W:0]   drop;
	logic [RANGE_W:0]          adr;
	logic [RANGE_W+10:0]       adr_k;
	logic [TIME_W-1:0]         el, el_c;
	logic [TIME_W+15:0]        rate_el;
	logic                      drop_big, drop_fast;

	assign dx  = DW'(word.position_x) - DW'(origin_x);
	assign dy  = DW'(word.position_y) - DW'(origin_y);
	assign sqx = dx * dx;
	assign sqy = dy * dy;
	assign dist2 = DIST_W'($unsigned(sqx)) + DIST_W'($unsigned(sqy));

	assign tgt_sq   = cfg.target_distance * cfg.target_distance;
	assign tgt_near = cfg.target_distance - NEAR_WINDOW_MM;
	assign near_sq  = tgt_near * tgt_near;
	assign near     = (cfg.target_distance <= NEAR_WINDOW_MM) ||
	                  (dist2 >= DIST_W'(near_sq));

	assign drop      = $signed({1'b0, last_down}) - $signed({1'b0, word.down_range});
	assign drop_big  = drop >= $signed({1'b0, cfg.step_threshold});
	assign adr       = (drop < 0) ? $unsigned(-drop) : $unsigned(drop);
	assign adr_k     = adr * MS_PER_S;
	assign el        = word.time_ms - last_time;
	assign el_c      = (el == '0) ? TIME_W'(1) : el;
	assign rate_el   = cfg.rate_threshold * el_c;
	assign drop_fast = (TIME_W + 16)'(adr_k) >= rate_el;

	assign flags.reached = word.position_valid && (dist2 >= DIST_W'(tgt_sq));
	assign flags.spike   = word.position_valid && word.down_valid && last_seen &&
	                       near && drop_big && drop_fast;

endmodule

// ----- rtl/vsg_axis.sv -----
// Velocity shaping for one axis: exponential smoothing, per-tick change
// limit and rounding to whole mm/s. Pure combinational. Depends on vsg_pkg.
module vsg_axis (
	input  logic signed [vsg_pkg::VEL_W-1:0]      desired,
	input  logic signed [vsg_pkg::FX_W-1:0]       smooth,
	input  logic signed [vsg_pkg::FX_W-1:0]       sent,
	input  logic [vsg_pkg::ALPHA_BITS-1:0]        alpha,
	input  logic [11:0]                           max_step,
	output logic signed [vsg_pkg::FX_W-1:0]       smooth_nxt,
	output logic signed [vsg_pkg::FX_W-1:0]       sent_nxt,
	output logic signed [vsg_pkg::VEL_W-1:0]      command
);
	import vsg_pkg::*;

	localparam int DW = FX_W + 1;
	localparam int PW = DW + ALPHA_BITS + 1;
	localparam int WW = DW - FRAC_BITS;
	localparam logic signed [DW-1:0] HALF = DW'(1) << (FRAC_BITS - 1);
	localparam logic signed [WW-1:0] LIM  = WW'(VEL_LIMIT);

	logic signed [DW-1:0] des_fx, diff, gap, dmax, dv, rnd;
	logic signed [PW-1:0] prod, prod_sh;
	logic signed [WW-1:0] whole;

	assign des_fx  = DW'(desired) <<< FRAC_BITS;
	assign diff    = des_fx - DW'(smooth);
	assign prod    = PW'(diff) * PW'($signed({1'b0, alpha}));
	assign prod_sh = prod >>> ALPHA_BITS;
	assign smooth_nxt = smooth + $signed(prod_sh[FX_W-1:0]);

	assign gap  = DW'(smooth_nxt) - DW'(sent);
	assign dmax = DW'({max_step, {FRAC_BITS{1'b0}}});
	assign dv   = (gap > dmax) ? dmax : ((gap < -dmax) ? -dmax : gap);
	assign sent_nxt = sent + $signed(dv[FX_W-1:0]);

	// round half up, then keep within the velocity limit
	assign rnd   = DW'(sent_nxt) + HALF;
	assign whole = rnd[DW-1:FRAC_BITS];
	assign command = (whole > LIM) ? VEL_W'(LIM) :
	                 ((whole < -LIM) ? VEL_W'(-LIM) : whole[VEL_W-1:0]);

endmodule

// ----- rtl/velocity_shaper_with_guards_top.sv -----
// Top level of the velocity shaper: input register, run control, stop checks,
// two shaping axes and the result register. Depends on vsg_pkg, vsg_cfg,
// vsg_guard and vsg_axis.
//
// Takes one tick word per clock while in_stall is low and returns one result
// word per tick, in order. An accepted word is held in the input register,
// worked through the distance/spike checks and both shaping axes, and goes
// into the output register once that is empty or not stalled. The run state
// (origin, phase, smoothed and sent velocities, last down reading) updates at
// the same edge as the result, so the next word sees it without a bubble.
// in_stall rises only when the input register is full and the output word is
// stalled. Registers must be written over the APB port only while no word is
// in flight; the block does not enforce it. They apply from the next word.
module velocity_shaper_with_guards_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  vsg_pkg::in_word_t            in_data,
	output logic                         out_valid,
	input  logic                         out_stall,
	output vsg_pkg::out_word_t           out_data,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [vsg_pkg::ADDR_W-1:0]   paddr,
	input  logic [vsg_pkg::DATA_W-1:0]   pwdata,
	output logic [vsg_pkg::DATA_W-1:0]   prdata,
	output logic                         pready
);
	import vsg_pkg::*;

	cfg_t       cfg;
	in_word_t   word_s1;
	logic       valid_s1;
	out_word_t  out_q;
	logic       out_valid_q;
	logic       advance, fire;

	phase_t                  run_phase_q;
	logic signed [POS_W-1:0] origin_x_q, origin_y_q;
	logic signed [FX_W-1:0]  smooth_vx_q, smooth_vy_q, sent_vx_q, sent_vy_q;
	logic [RANGE_W-1:0]      last_down_q;
	logic [TIME_W-1:0]       last_time_q;
	logic                    last_seen_q;

	phase_t                  ph0, ph_nxt;
	logic signed [FX_W-1:0]  base_fx, sm_x0, sent_x0, sm_y0, sent_y0;
	logic signed [FX_W-1:0]  sm_x1, sent_x1, sm_y1, sent_y1;
	logic signed [POS_W-1:0] org_x, org_y;
	logic                    seen0, latch, moving, run, upd_down, spike;
	guard_t                  flags;

	logic [VEL_W-1:0]        abs_base, vmax_raw, vmax;
	logic signed [VEL_W+1:0] des_x_raw, des_y_raw, vmax_s;
	logic signed [VEL_W-1:0] des_x, des_y, cmd_x, cmd_y;
	out_word_t               result;

	vsg_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// handshake
	assign advance   = !out_valid_q || !out_stall;
	assign fire      = valid_s1 && advance;
	assign in_stall  = valid_s1 && !advance;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			word_s1 <= in_data;
		end
	end

	// run control
	assign base_fx = FX_W'(cfg.base_velocity) <<< FRAC_BITS;
	assign ph0     = word_s1.restart ? PH_WAITING : run_phase_q;
	assign sm_x0   = word_s1.restart ? base_fx : smooth_vx_q;
	assign sent_x0 = word_s1.restart ? base_fx : sent_vx_q;
	assign sm_y0   = word_s1.restart ? '0 : smooth_vy_q;
	assign sent_y0 = word_s1.restart ? '0 : sent_vy_q;
	assign seen0   = word_s1.restart ? 1'b0 : last_seen_q;
	assign latch   = (ph0 == PH_WAITING) && word_s1.position_valid;
	assign org_x   = latch ? word_s1.position_x : origin_x_q;
	assign org_y   = latch ? word_s1.position_y : origin_y_q;
	assign moving  = (ph0 == PH_MOVING) || latch;

	vsg_guard u_guard (
		.word      (word_s1),
		.origin_x  (org_x),
		.origin_y  (org_y),
		.cfg       (cfg),
		.last_down (last_down_q),
		.last_time (last_time_q),
		.last_seen (seen0),
		.flags     (flags)
	);

	assign run      = moving && !flags.reached;
	assign upd_down = run && word_s1.position_valid && word_s1.down_valid;
	assign spike    = run && flags.spike;

	always_comb begin
		if (moving && flags.reached) begin
			ph_nxt = PH_REACHED;
		end else if (spike) begin
			ph_nxt = PH_SPIKE;
		end else if (moving) begin
			ph_nxt = PH_MOVING;
		end else begin
			ph_nxt = ph0;
		end
	end

	// desired velocity with push-away, clamped per axis
	assign abs_base = cfg.base_velocity[VEL_W-1] ? $unsigned(-cfg.base_velocity)
	                                             : $unsigned(cfg.base_velocity);
	assign vmax_raw = (abs_base > VEL_W'(cfg.push_velocity)) ? abs_base
	                                                         : VEL_W'(cfg.push_velocity);
	assign vmax     = (vmax_raw > VEL_LIMIT) ? VEL_LIMIT : vmax_raw;
	assign vmax_s   = $signed((VEL_W + 2)'(vmax));

	always_comb begin
		des_x_raw = (VEL_W + 2)'(cfg.base_velocity);
		des_y_raw = '0;
		if (word_s1.front_range < cfg.avoid_distance)
			des_x_raw = des_x_raw - $signed((VEL_W + 2)'(cfg.push_velocity));
		if (word_s1.back_range < cfg.avoid_distance)
			des_x_raw = des_x_raw + $signed((VEL_W + 2)'(cfg.push_velocity));
		if (word_s1.left_range < cfg.avoid_distance)
			des_y_raw = des_y_raw - $signed((VEL_W + 2)'(cfg.push_velocity));
		if (word_s1.right_range < cfg.avoid_distance)
			des_y_raw = des_y_raw + $signed((VEL_W + 2)'(cfg.push_velocity));
	end

	assign des_x = (des_x_raw > vmax_s) ? VEL_W'(vmax_s) :
	               ((des_x_raw < -vmax_s) ? VEL_W'(-vmax_s) : des_x_raw[VEL_W-1:0]);
	assign des_y = (des_y_raw > vmax_s) ? VEL_W'(vmax_s) :
	               ((des_y_raw < -vmax_s) ? VEL_W'(-vmax_s) : des_y_raw[VEL_W-1:0]);

	vsg_axis u_axis_x (
		.desired    (des_x),
		.smooth     (sm_x0),
		.sent       (sent_x0),
		.alpha      (cfg.smoothing_alpha),
		.max_step   (cfg.max_step_change),
		.smooth_nxt (sm_x1),
		.sent_nxt   (sent_x1),
		.command    (cmd_x)
	);

	vsg_axis u_axis_y (
		.desired    (des_y),
		.smooth     (sm_y0),
		.sent       (sent_y0),
		.alpha      (cfg.smoothing_alpha),
		.max_step   (cfg.max_step_change),
		.smooth_nxt (sm_y1),
		.sent_nxt   (sent_y1),
		.command    (cmd_y)
	);

	always_comb begin
		result.command_vx = (run && !spike) ? cmd_x : '0;
		result.command_vy = (run && !spike) ? cmd_y : '0;
		result.run_status = ph_nxt;
	end

	// run state, updated with each result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_phase_q <= PH_WAITING;
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			smooth_vx_q <= FX_W'(BASE_VELOCITY_RST) <<< FRAC_BITS;
			sent_vx_q   <= FX_W'(BASE_VELOCITY_RST) <<< FRAC_BITS;
			smooth_vy_q <= '0;
			sent_vy_q   <= '0;
			last_down_q <= '0;
			last_time_q <= '0;
			last_seen_q <= 1'b0;
		end else if (fire) begin
			run_phase_q <= ph_nxt;
			if (latch) begin
				origin_x_q <= word_s1.position_x;
				origin_y_q <= word_s1.position_y;
			end
			smooth_vx_q <= run ? sm_x1 : sm_x0;
			sent_vx_q   <= run ? sent_x1 : sent_x0;
			smooth_vy_q <= run ? sm_y1 : sm_y0;
			sent_vy_q   <= run ? sent_y1 : sent_y0;
			if (upd_down) begin
				last_down_q <= word_s1.down_range;
				last_time_q <= word_s1.time_ms;
			end
			last_seen_q <= upd_down || seen0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_q <= result;
		end
	end

	a_stopped_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_q.run_status != PH_MOVING) |->
			(out_q.command_vx == '0) && (out_q.command_vy == '0))
		else $error("command not zero while not moving");

	a_stall_needs_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q)
		else $error("input stalled with room to take a word");

	a_fire_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> out_valid_q)
		else $error("processed word not presented");

	a_reached_holds: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !word_s1.restart && (run_phase_q == PH_REACHED) |=>
			(out_q.run_status == PH_REACHED) && (run_phase_q == PH_REACHED))
		else $error("distance stop left without restart");

endmodule
